>>> design/ctts_pkg.sv
`default_nettype none

package ctts_pkg;

    // Default geometry of the oscillators.
    localparam int PHASE_BITS_DEF     = 24;
    localparam int SINE_ADDR_BITS_DEF = 10;

    // Configuration port.
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_GAIN_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_LOW_TONE_STEP  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_TONE_STEP = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TREMOLO_STEP   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_STEP    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TREMOLO_OFFSET = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TREMOLO_DEPTH  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_GAIN    = 4'd7;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] low_tone_step;
        logic [CFG_DATA_W-1:0] high_tone_step;
        logic [CFG_DATA_W-1:0] tremolo_step;
        logic [CFG_DATA_W-1:0] sample_count;
        logic [CFG_DATA_W-1:0] weight_step;
        logic [CFG_GAIN_W-1:0] tremolo_offset;
        logic [CFG_GAIN_W-1:0] tremolo_depth;
        logic [CFG_GAIN_W-1:0] output_gain;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        low_tone_step:  24'd152176,
        high_tone_step: 24'd608703,
        tremolo_step:   24'd3044,
        sample_count:   24'd220500,
        weight_step:    24'd76,
        tremolo_offset: 16'd39322,
        tremolo_depth:  16'd19661,
        output_gain:    16'd24576
    };

    // Oscillator slots.
    localparam int OSC_COUNT = 3;
    localparam int OSC_W     = 2;
    localparam logic [OSC_W-1:0] OSC_LOW  = 2'd0;
    localparam logic [OSC_W-1:0] OSC_HIGH = 2'd1;
    localparam logic [OSC_W-1:0] OSC_TREM = 2'd2;

    // Crossfade weight (Q0.24 with room for one) and sample index.
    localparam int WEIGHT_W = 25;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 25'h100_0000;
    localparam int INDEX_W = 24;

    // Quarter-wave polynomial, Q16.
    localparam logic [16:0] Z_ONE  = 17'h1_0000;
    localparam logic [16:0] SIN_C1 = 17'd102944;
    localparam logic [15:0] SIN_C3 = 16'd42334;
    localparam logic [12:0] SIN_C5 = 13'd5209;

    // Digit-serial multiplier geometry.
    localparam int MUL_A_W     = 26;
    localparam int MUL_B_W     = 20;
    localparam int DIGIT_W     = 4;
    localparam int MUL_DIGITS  = MUL_B_W / DIGIT_W;
    localparam int MUL_CNT_W   = $clog2(MUL_DIGITS);
    localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
    localparam int MUL_SUM_W   = MUL_A_W + DIGIT_W + 1;

    // Output sample.
    localparam int SAMPLE_W = 8;
    localparam logic [SAMPLE_W-1:0] SAMPLE_ZERO = 8'd128;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX  = 8'd255;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                final_sample;
        logic                finished;
    } t_result;

    typedef enum logic [3:0] {
        SQ_IDLE,
        SQ_CHECK,
        SQ_Z2,
        SQ_C5,
        SQ_T,
        SQ_S,
        SQ_MIX,
        SQ_ENV,
        SQ_Y1,
        SQ_Y2,
        SQ_DONE
    } t_seq_state;

endpackage

`default_nettype wire

>>> design/crossfade_tremolo_tone_synth_top.sv
// Two-tone crossfade synthesizer with tremolo, one unsigned 8-bit sample per tick.
//
// Input channel: i_in_valid / o_in_stall with i_restart. Each transfer is one tick;
// i_restart clears phases, crossfade weight and sample index before that tick.
// Output channel: o_out_valid / i_out_stall with o_sample, o_final_sample and
// o_finished, exactly one result per tick, in order.
// Configuration: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data; write
// only while no tick is in flight. Unknown indexes are dropped.
//
// All products go through one radix-16 digit-serial multiplier: each is launched,
// worked through five digits and captured, sixteen products per sample. A new tick
// is taken only once the previous one has left the sequencer. Once the sweep is over
// a tick skips the multiplier and goes straight from the check to its result.
// A finished result waits in the output register while the next tick is computed;
// if that register is still held by i_out_stall the next result waits in the
// sequencer and no further tick is taken.
// Reset (i_rst_n low, synchronous) reloads the default registers, clears all
// oscillator state and drops any pending result.
`default_nettype none

module crossfade_tremolo_tone_synth_top #(
    parameter int PHASE_BITS     = ctts_pkg::PHASE_BITS_DEF,
    parameter int SINE_ADDR_BITS = ctts_pkg::SINE_ADDR_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic                            i_restart,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [ctts_pkg::SAMPLE_W-1:0]        o_sample,
    output logic                                 o_final_sample,
    output logic                                 o_finished,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [ctts_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ctts_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ctts_pkg::*;

    t_cfg    w_cfg;
    logic [OSC_COUNT-1:0][PHASE_BITS-1:0] w_phases;
    logic [WEIGHT_W-1:0] w_weight;
    logic [INDEX_W-1:0]  w_index;
    logic    w_seq_idle;
    logic    w_res_valid;
    logic    w_advance;
    t_result w_res;
    logic    w_in_accept;
    logic    w_take;
    logic    r_out_valid, n_out_valid;
    t_result r_out;

    assign o_in_stall  = !w_seq_idle || !i_rst_n;
    assign o_cfg_ready = i_rst_n;
    assign w_in_accept = i_in_valid && !o_in_stall;

    ctts_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    ctts_osc_state #(
        .PHASE_BITS (PHASE_BITS)
    ) u_osc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (w_in_accept && i_restart),
        .i_advance (w_advance),
        .i_cfg     (w_cfg),
        .o_phases  (w_phases),
        .o_weight  (w_weight),
        .o_index   (w_index)
    );

    ctts_seq #(
        .PHASE_BITS     (PHASE_BITS),
        .SINE_ADDR_BITS (SINE_ADDR_BITS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_in_accept),
        .i_take      (w_take),
        .i_cfg       (w_cfg),
        .i_phases    (w_phases),
        .i_weight    (w_weight),
        .i_index     (w_index),
        .o_idle      (w_seq_idle),
        .o_res_valid (w_res_valid),
        .o_advance   (w_advance),
        .o_res       (w_res)
    );

    // The output register takes a new result when empty or when its current
    // one transfers in the same cycle.
    assign w_take      = w_res_valid && (!r_out_valid || !i_out_stall);
    assign n_out_valid = w_take || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sample       = r_out.sample;
    assign o_final_sample = r_out.final_sample;
    assign o_finished     = r_out.finished;

endmodule

`default_nettype wire

>>> design/ctts_cfg_regs.sv
`default_nettype none

module ctts_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_we,
    input  wire logic [ctts_pkg::CFG_IDX_W-1:0] i_index,
    input  wire logic [ctts_pkg::CFG_DATA_W-1:0] i_data,
    output ctts_pkg::t_cfg                      o_cfg
);
    import ctts_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_we) begin
            case (i_index)
                CFG_LOW_TONE_STEP:  n_cfg.low_tone_step  = i_data;
                CFG_HIGH_TONE_STEP: n_cfg.high_tone_step = i_data;
                CFG_TREMOLO_STEP:   n_cfg.tremolo_step   = i_data;
                CFG_SAMPLE_COUNT:   n_cfg.sample_count   = i_data;
                CFG_WEIGHT_STEP:    n_cfg.weight_step    = i_data;
                CFG_TREMOLO_OFFSET: n_cfg.tremolo_offset = i_data[CFG_GAIN_W-1:0];
                CFG_TREMOLO_DEPTH:  n_cfg.tremolo_depth  = i_data[CFG_GAIN_W-1:0];
                CFG_OUTPUT_GAIN:    n_cfg.output_gain    = i_data[CFG_GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> design/ctts_osc_state.sv
`default_nettype none

module ctts_osc_state #(
    parameter int PHASE_BITS = ctts_pkg::PHASE_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_clear,
    input  wire logic                        i_advance,
    input  ctts_pkg::t_cfg                   i_cfg,
    output logic [ctts_pkg::OSC_COUNT-1:0][PHASE_BITS-1:0] o_phases,
    output logic [ctts_pkg::WEIGHT_W-1:0]   o_weight,
    output logic [ctts_pkg::INDEX_W-1:0]    o_index
);
    import ctts_pkg::*;

    localparam int WSUM_W = WEIGHT_W + 1;

    logic [OSC_COUNT-1:0][PHASE_BITS-1:0] r_phase, n_phase;
    logic [OSC_COUNT-1:0][PHASE_BITS-1:0] w_step;
    logic [WEIGHT_W-1:0] r_weight, n_weight;
    logic [INDEX_W-1:0]  r_index, n_index;
    logic [WSUM_W-1:0]   w_wsum;

    // Steps are zero-extended or cut to the phase width, so phases wrap there.
    assign w_step[OSC_LOW]  = PHASE_BITS'(i_cfg.low_tone_step);
    assign w_step[OSC_HIGH] = PHASE_BITS'(i_cfg.high_tone_step);
    assign w_step[OSC_TREM] = PHASE_BITS'(i_cfg.tremolo_step);

    assign w_wsum = {1'b0, r_weight} + WSUM_W'(i_cfg.weight_step);

    always_comb begin
        n_phase  = r_phase;
        n_weight = r_weight;
        n_index  = r_index;
        if (i_clear) begin
            n_phase  = '0;
            n_weight = '0;
            n_index  = '0;
        end else if (i_advance) begin
            for (int k = 0; k < OSC_COUNT; k++) begin
                n_phase[k] = r_phase[k] + w_step[k];
            end
            n_weight = (w_wsum > {1'b0, WEIGHT_ONE}) ? WEIGHT_ONE : w_wsum[WEIGHT_W-1:0];
            n_index  = r_index + INDEX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= '0;
            r_weight <= '0;
            r_index  <= '0;
        end else begin
            r_phase  <= n_phase;
            r_weight <= n_weight;
            r_index  <= n_index;
        end
    end

    assign o_phases = r_phase;
    assign o_weight = r_weight;
    assign o_index  = r_index;

endmodule

`default_nettype wire

>>> design/ctts_serial_mult.sv
`default_nettype none

module ctts_serial_mult (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    input  wire logic signed [ctts_pkg::MUL_A_W-1:0] i_a,
    input  wire logic signed [ctts_pkg::MUL_B_W-1:0] i_b,
    output logic                                    o_done,
    output logic signed [ctts_pkg::MUL_P_W-1:0]     o_product
);
    import ctts_pkg::*;

    localparam logic [MUL_CNT_W-1:0] CNT_LAST = MUL_CNT_W'(MUL_DIGITS - 1);

    logic                         r_run, n_run;
    logic                         r_done, n_done;
    logic [MUL_CNT_W-1:0]         r_cnt;
    logic signed [MUL_A_W-1:0]    r_a;
    logic [MUL_B_W-1:0]           r_b;
    logic signed [MUL_A_W:0]      r_hi;
    logic [MUL_B_W-1:0]           r_lo;

    logic                         w_last;
    logic signed [DIGIT_W:0]      w_digit;
    logic signed [MUL_SUM_W-1:0]  w_pp;
    logic signed [MUL_SUM_W-1:0]  w_sum;

    // The multiplier operand goes out one radix-16 digit per cycle, least
    // significant first. Its top digit carries the sign, so it is taken as
    // a signed digit and the others as unsigned ones.
    assign w_last  = (r_cnt == CNT_LAST);
    assign w_digit = w_last ? $signed({r_b[DIGIT_W-1], r_b[DIGIT_W-1:0]})
                            : $signed({1'b0, r_b[DIGIT_W-1:0]});
    assign w_pp    = MUL_SUM_W'(r_a) * MUL_SUM_W'(w_digit);
    assign w_sum   = MUL_SUM_W'(r_hi) + w_pp;

    always_comb begin
        n_run  = r_run;
        n_done = 1'b0;
        if (i_start) begin
            n_run = 1'b1;
        end else if (r_run && w_last) begin
            n_run  = 1'b0;
            n_done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_hi  <= '0;
            r_cnt <= '0;
        end else if (r_run) begin
            // Low digits of the running sum are final and drop into r_lo.
            r_hi  <= w_sum[MUL_SUM_W-1:DIGIT_W];
            r_lo  <= {w_sum[DIGIT_W-1:0], r_lo[MUL_B_W-1:DIGIT_W]};
            r_b   <= r_b >> DIGIT_W;
            r_cnt <= r_cnt + MUL_CNT_W'(1);
        end
    end

    assign o_done    = r_done;
    assign o_product = {r_hi[MUL_A_W-1:0], r_lo};

endmodule

`default_nettype wire

>>> design/ctts_seq.sv
`default_nettype none

module ctts_seq #(
    parameter int PHASE_BITS     = ctts_pkg::PHASE_BITS_DEF,
    parameter int SINE_ADDR_BITS = ctts_pkg::SINE_ADDR_BITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic                      i_take,
    input  ctts_pkg::t_cfg                 i_cfg,
    input  wire logic [ctts_pkg::OSC_COUNT-1:0][PHASE_BITS-1:0] i_phases,
    input  wire logic [ctts_pkg::WEIGHT_W-1:0] i_weight,
    input  wire logic [ctts_pkg::INDEX_W-1:0]  i_index,
    output logic                           o_idle,
    output logic                           o_res_valid,
    output logic                           o_advance,
    output ctts_pkg::t_result              o_res
);
    import ctts_pkg::*;

    t_seq_state            r_state, n_state;
    logic [OSC_W-1:0]      r_osc, n_osc;
    logic                  r_issued, n_issued;

    logic                  w_is_mul;
    logic                  w_mul_start;
    logic                  w_mul_done;
    logic signed [MUL_A_W-1:0] w_mul_a;
    logic signed [MUL_B_W-1:0] w_mul_b;
    logic signed [MUL_P_W-1:0] w_prod;

    // Sine lookup address of the oscillator being worked on.
    logic [PHASE_BITS-1:0]     w_phase;
    logic [SINE_ADDR_BITS-1:0] w_addr;
    logic [1:0]                w_quad;
    logic [15:0]               w_z_base;
    logic [16:0]               w_z;

    logic [16:0]               r_z2;
    logic [15:0]               r_t1;
    logic [16:0]               r_t2;
    logic signed [15:0]        r_sine [OSC_COUNT];
    logic signed [15:0]        r_mix;
    logic signed [17:0]        r_env;
    logic signed [17:0]        r_y1;
    t_result                   r_res;

    logic [14:0]               w_s_mag;
    logic signed [15:0]        w_sine;
    logic signed [16:0]        w_diff;
    logic signed [17:0]        w_mix_sum;
    logic signed [17:0]        w_env;
    logic signed [18:0]        w_y2;
    logic signed [26:0]        w_y127;
    logic signed [12:0]        w_v;
    logic [SAMPLE_W-1:0]       w_sample;
    logic                      w_finished;
    logic                      w_final;

    assign w_phase  = i_phases[r_osc];
    assign w_addr   = w_phase[PHASE_BITS-1 -: SINE_ADDR_BITS];
    assign w_quad   = w_addr[SINE_ADDR_BITS-1 -: 2];
    assign w_z_base = {w_addr[SINE_ADDR_BITS-3:0], {(18 - SINE_ADDR_BITS){1'b0}}};
    // Second and fourth quadrants run the quarter wave backwards.
    assign w_z      = w_quad[0] ? (Z_ONE - {1'b0, w_z_base}) : {1'b0, w_z_base};

    assign w_finished = (i_index >= i_cfg.sample_count);
    assign w_final    = ((i_index + INDEX_W'(1)) == i_cfg.sample_count);

    // Bring the quarter wave to Q1.15 and cap it just below one.
    assign w_s_mag = w_prod[32] ? 15'h7FFF : w_prod[31:17];
    assign w_sine  = w_quad[1] ? -$signed({1'b0, w_s_mag}) : $signed({1'b0, w_s_mag});

    // The blend is low + w*(high - low), which floors the same as the
    // weighted sum of both tones.
    assign w_diff    = 17'(r_sine[OSC_HIGH]) - 17'(r_sine[OSC_LOW]);
    assign w_mix_sum = $signed(w_prod[41:24]) + 18'(r_sine[OSC_LOW]);
    assign w_env     = $signed({2'b00, i_cfg.tremolo_offset}) + $signed(w_prod[32:15]);
    assign w_y2      = $signed(w_prod[32:14]);
    assign w_y127    = (27'(w_y2) <<< 7) - 27'(w_y2);
    assign w_v       = 13'($signed(w_y127[26:15])) + 13'sd128;

    always_comb begin
        if (w_v < 13'sd0) begin
            w_sample = '0;
        end else if (w_v > 13'sd255) begin
            w_sample = SAMPLE_MAX;
        end else begin
            w_sample = w_v[SAMPLE_W-1:0];
        end
    end

    ctts_serial_mult u_mult (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_mul_start),
        .i_a       (w_mul_a),
        .i_b       (w_mul_b),
        .o_done    (w_mul_done),
        .o_product (w_prod)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            SQ_IDLE:  if (i_start) n_state = SQ_CHECK;
            SQ_CHECK: n_state = w_finished ? SQ_DONE : SQ_Z2;
            SQ_Z2:    if (w_mul_done) n_state = SQ_C5;
            SQ_C5:    if (w_mul_done) n_state = SQ_T;
            SQ_T:     if (w_mul_done) n_state = SQ_S;
            SQ_S:     if (w_mul_done) n_state = (r_osc == OSC_TREM) ? SQ_MIX : SQ_Z2;
            SQ_MIX:   if (w_mul_done) n_state = SQ_ENV;
            SQ_ENV:   if (w_mul_done) n_state = SQ_Y1;
            SQ_Y1:    if (w_mul_done) n_state = SQ_Y2;
            SQ_Y2:    if (w_mul_done) n_state = SQ_DONE;
            SQ_DONE:  if (i_take) n_state = SQ_IDLE;
            default:  n_state = SQ_IDLE;
        endcase
    end

    // Oscillator counter and launch flag.
    always_comb begin
        n_osc    = r_osc;
        n_issued = r_issued;
        if (r_state == SQ_CHECK) begin
            n_osc = OSC_LOW;
        end else if (r_state == SQ_S && w_mul_done) begin
            n_osc = r_osc + OSC_W'(1);
        end
        if (w_mul_done) begin
            n_issued = 1'b0;
        end else if (w_mul_start) begin
            n_issued = 1'b1;
        end
    end

    // Outputs: multiplier operands and handshake toward the top level.
    always_comb begin
        w_is_mul = 1'b1;
        w_mul_a  = '0;
        w_mul_b  = '0;
        case (r_state)
            SQ_Z2: begin
                w_mul_a = MUL_A_W'(w_z);
                w_mul_b = MUL_B_W'(w_z);
            end
            SQ_C5: begin
                w_mul_a = MUL_A_W'(SIN_C5);
                w_mul_b = MUL_B_W'(r_z2);
            end
            SQ_T: begin
                w_mul_a = MUL_A_W'(r_t1);
                w_mul_b = MUL_B_W'(r_z2);
            end
            SQ_S: begin
                w_mul_a = MUL_A_W'(r_t2);
                w_mul_b = MUL_B_W'(w_z);
            end
            SQ_MIX: begin
                w_mul_a = MUL_A_W'(i_weight);
                w_mul_b = MUL_B_W'(w_diff);
            end
            SQ_ENV: begin
                w_mul_a = MUL_A_W'(i_cfg.tremolo_depth);
                w_mul_b = MUL_B_W'(r_sine[OSC_TREM]);
            end
            SQ_Y1: begin
                w_mul_a = MUL_A_W'(r_env);
                w_mul_b = MUL_B_W'(r_mix);
            end
            SQ_Y2: begin
                w_mul_a = MUL_A_W'(r_y1);
                w_mul_b = MUL_B_W'(i_cfg.output_gain);
            end
            default: w_is_mul = 1'b0;
        endcase
        w_mul_start = w_is_mul && !r_issued;
        o_idle      = (r_state == SQ_IDLE);
        o_res_valid = (r_state == SQ_DONE);
        o_advance   = o_res_valid && i_take && !r_res.finished;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= SQ_IDLE;
            r_osc    <= OSC_LOW;
            r_issued <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_osc    <= n_osc;
            r_issued <= n_issued;
        end
    end

    // Each product is floored to its fixed-point format as it is captured.
    always_ff @(posedge i_clk) begin
        if (r_state == SQ_CHECK && w_finished) begin
            r_res <= '{sample: SAMPLE_ZERO, final_sample: 1'b0, finished: 1'b1};
        end
        if (w_mul_done) begin
            case (r_state)
                SQ_Z2:  r_z2 <= w_prod[32:16];
                SQ_C5:  r_t1 <= SIN_C3 - {3'b000, w_prod[28:16]};
                SQ_T:   r_t2 <= SIN_C1 - {1'b0, w_prod[31:16]};
                SQ_S:   r_sine[r_osc] <= w_sine;
                SQ_MIX: r_mix <= w_mix_sum[15:0];
                SQ_ENV: r_env <= w_env;
                SQ_Y1:  r_y1 <= $signed(w_prod[33:16]);
                SQ_Y2:  r_res <= '{sample: w_sample, final_sample: w_final, finished: 1'b0};
                default: ;
            endcase
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

>>> design/ctts_checker.sv
`default_nettype none

module ctts_checker (
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     i_in_valid,
    input wire logic                     o_in_stall,
    input wire logic                     o_out_valid,
    input wire logic                     i_out_stall,
    input wire logic [ctts_pkg::SAMPLE_W-1:0] o_sample,
    input wire logic                     o_final_sample,
    input wire logic                     o_finished
);
    import ctts_pkg::*;

    // A held result must not move.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_sample)
            && $stable(o_final_sample) && $stable(o_finished))
        else $error("result changed while stalled");

    // Ticks are worked on one at a time.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("tick taken while another is in flight");

    // After the sweep the output sits at mid scale and is never the last sample.
    a_finished_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_finished |-> o_sample == SAMPLE_ZERO && !o_final_sample)
        else $error("finished result is not silent");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result present after reset");

endmodule

bind crossfade_tremolo_tone_synth_top ctts_checker u_checker (.*);

`default_nettype wire
